/* hdl/dlr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dlr_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int DIM_W       = 13;
  localparam int COLOR_W     = 32;
  localparam int COORD_IN_W  = 16;
  localparam int POS_W       = 17;
  localparam int PIX_COORD_W = 18;
  localparam int ADDR_W      = 24;
  localparam int PROD_W      = 2 * DIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLOR  = 2'd2;

  localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd1024;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd768;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 32'h00FF_FFFF;

  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SETUP,
    ST_DIV,
    ST_STEP,
    ST_EMIT
  } dlr_state_t;

  typedef struct packed {
    logic signed [PIX_COORD_W-1:0] x;
    logic signed [PIX_COORD_W-1:0] y;
    logic                          last;
  } dlr_pix_req_t;

endpackage

`default_nettype wire

/* hdl/dlr_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module dlr_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r,  rem_nxt;
  logic [NUM_W-1:0] quo_r,  quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             fits;

  always_comb begin
    shifted  = {rem_r, quo_r[NUM_W-1]};
    diff     = {1'b0, shifted} - {2'b00, den_r};
    fits     = ~diff[DEN_W+1];
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* hdl/dlr_pixel.sv */
`timescale 1ns / 1ps
`default_nettype none

module dlr_pixel (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [dlr_pkg::DIM_W-1:0]    window_width,
  input  wire logic [dlr_pkg::DIM_W-1:0]    window_height,
  input  wire logic [dlr_pkg::COLOR_W-1:0]  draw_color,
  input  wire logic                         start,
  input  wire dlr_pkg::dlr_pix_req_t        req,
  output logic                              ready,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [dlr_pkg::ADDR_W-1:0]        out_pixel_address,
  output logic [dlr_pkg::COLOR_W-1:0]       out_pixel_color,
  output logic                              out_write_valid,
  output logic                              out_last_pixel
);

  import dlr_pkg::*;

  logic               a_v_r;
  logic               a_in_win_r;
  logic [PROD_W-1:0]  a_prod_r;
  logic [DIM_W-1:0]   a_x_r;
  logic               a_last_r;
  logic [COLOR_W-1:0] a_color_r;

  logic               out_valid_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [COLOR_W-1:0] color_r;
  logic               wvalid_r;
  logic               last_r;

  logic               in_win;
  logic               advance;
  logic [PROD_W-1:0]  addr_sum;

  always_comb begin
    in_win = ~req.x[PIX_COORD_W-1]
           && (req.x[PIX_COORD_W-2:0] < (PIX_COORD_W-1)'(window_width))
           && ~req.y[PIX_COORD_W-1]
           && (req.y[PIX_COORD_W-2:0] < (PIX_COORD_W-1)'(window_height));
    advance  = a_v_r && (!out_valid_r || !out_stall);
    addr_sum = a_prod_r + PROD_W'(a_x_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        a_v_r <= 1'b1;
      end else if (advance) begin
        a_v_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (start) begin
      a_in_win_r <= in_win;
      a_prod_r   <= req.y[DIM_W-1:0] * window_width;
      a_x_r      <= req.x[DIM_W-1:0];
      a_last_r   <= req.last;
      a_color_r  <= draw_color;
    end
    if (advance) begin
      addr_r   <= a_in_win_r ? addr_sum[ADDR_W-1:0] : '0;
      color_r  <= a_color_r;
      wvalid_r <= a_in_win_r;
      last_r   <= a_last_r;
    end
  end

  assign ready             = ~a_v_r;
  assign out_valid         = out_valid_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_color   = color_r;
  assign out_write_valid   = wvalid_r;
  assign out_last_pixel    = last_r;

endmodule

`default_nettype wire

/* hdl/dda_line_rasterizer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// DDA line rasterizer. An item with opcode 0 loads a line from its two endpoints, and each
// item with opcode 1 then yields one pixel (linear address, color, in-window flag, last flag)
// until the line ends at its end point or at the window edge on the major axis. A load holds
// the input while the restoring divider forms the slope one quotient bit per cycle; a
// single-point line skips the divider. A step holds the input until its pixel, if any, is
// passed to the pixel stage, which holds the row multiply; from there the pixel goes to the
// output register. The output register lets the next item be accepted while a pixel still
// waits to be taken. Window sizes take the low DIM_W bits of the written data, and values
// above MAX_DIM saturate to MAX_DIM.
module dda_line_rasterizer_unit #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [dlr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dlr_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_opcode,
  input  wire logic signed [dlr_pkg::COORD_IN_W-1:0] in_start_x,
  input  wire logic signed [dlr_pkg::COORD_IN_W-1:0] in_start_y,
  input  wire logic signed [dlr_pkg::COORD_IN_W-1:0] in_end_x,
  input  wire logic signed [dlr_pkg::COORD_IN_W-1:0] in_end_y,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [dlr_pkg::ADDR_W-1:0]                out_pixel_address,
  output logic [dlr_pkg::COLOR_W-1:0]               out_pixel_color,
  output logic                                      out_write_valid,
  output logic                                      out_last_pixel
);

  import dlr_pkg::*;

  localparam int MAG_W   = COORD_IN_W;
  localparam int NUM_W   = MAG_W + FRAC_BITS;
  localparam int SLOPE_W = NUM_W + 1;
  localparam int ACC_W   = PIX_COORD_W + FRAC_BITS;
  localparam logic [DIM_W-1:0] DIM_CAP =
    (MAX_DIM < (2 ** DIM_W)) ? DIM_W'(MAX_DIM) : {DIM_W{1'b1}};

  dlr_state_t state_r, state_nxt;

  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic [COLOR_W-1:0] color_r;
  logic [DIM_W-1:0]   cfg_dim;

  logic signed [COORD_IN_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [POS_W-1:0]      dx_r, dy_r;

  logic signed [POS_W-1:0]   pos_r;
  logic signed [POS_W-1:0]   end_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [SLOPE_W-1:0] slope_r;
  logic                      x_major_r;
  logic                      active_r;
  logic                      single_r;
  logic                      neg_r;
  dlr_pix_req_t              req_r;

  logic                 accept;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quo;
  logic                 pix_start;
  logic                 pix_ready;

  logic [POS_W-1:0]            adx, ady, dmaj, dmin;
  logic                        su_xm, su_single, su_swap, su_neg;
  logic signed [COORD_IN_W-1:0] su_ms, su_me, su_ns;
  logic [NUM_W-1:0]            su_num;

  logic signed [POS_W-1:0]       dim_s, limit;
  logic                          st_over, st_last;
  logic [ACC_W-1:0]              acc_biased;
  logic signed [PIX_COORD_W-1:0] minor, pos_ext;

  assign accept = in_valid && !in_stall;

  always_comb begin
    cfg_dim = cfg_wdata[DIM_W-1:0];
    if (cfg_dim > DIM_CAP) begin
      cfg_dim = DIM_CAP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      color_r  <= COLOR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_WIDTH) begin
        width_r <= cfg_dim;
      end
      if (cfg_index == CFG_IDX_HEIGHT) begin
        height_r <= cfg_dim;
      end
      if (cfg_index == CFG_IDX_COLOR) begin
        color_r <= cfg_wdata[COLOR_W-1:0];
      end
    end
  end

  always_comb begin
    adx       = dx_r[POS_W-1] ? POS_W'(-dx_r) : POS_W'(dx_r);
    ady       = dy_r[POS_W-1] ? POS_W'(-dy_r) : POS_W'(dy_r);
    su_single = (dx_r == '0) && (dy_r == '0);
    su_xm     = ((dx_r != '0) && (adx >= ady)) || (dy_r == '0);
    su_swap   = su_xm ? dx_r[POS_W-1] : dy_r[POS_W-1];
    su_neg    = su_swap ^ (su_xm ? dy_r[POS_W-1] : dx_r[POS_W-1]);
    dmaj      = su_xm ? adx : ady;
    dmin      = su_xm ? ady : adx;
    su_ms     = su_xm ? (su_swap ? ex_r : sx_r) : (su_swap ? ey_r : sy_r);
    su_me     = su_xm ? (su_swap ? sx_r : ex_r) : (su_swap ? sy_r : ey_r);
    su_ns     = su_xm ? (su_swap ? ey_r : sy_r) : (su_swap ? ex_r : sx_r);
    su_num    = {dmin[MAG_W-1:0], {FRAC_BITS{1'b0}}};
  end

  always_comb begin
    dim_s      = $signed(POS_W'(x_major_r ? width_r : height_r));
    limit      = (!single_r && (dim_s < end_r)) ? dim_s : end_r;
    st_over    = pos_r > limit;
    st_last    = pos_r >= limit;
    acc_biased = acc_r + (acc_r[ACC_W-1] ? ACC_W'({FRAC_BITS{1'b1}}) : ACC_W'(0));
    minor      = $signed(acc_biased[ACC_W-1:FRAC_BITS]);
    pos_ext    = PIX_COORD_W'(pos_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_opcode == OPC_LOAD) begin
          state_nxt = ST_DELTA;
        end else if (accept && active_r) begin
          state_nxt = ST_STEP;
        end
      end
      ST_DELTA: state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = su_single ? ST_IDLE : ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_STEP: state_nxt = st_over ? ST_IDLE : ST_EMIT;
      ST_EMIT: begin
        if (pix_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    pix_start = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_stall  = 1'b0;
      ST_SETUP: div_start = !su_single;
      ST_EMIT:  pix_start = pix_ready;
      default:  in_stall  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SETUP) begin
        active_r <= 1'b1;
      end else if (state_r == ST_STEP && (st_over || st_last)) begin
        active_r <= 1'b0;
      end
    end

    if (state_r == ST_IDLE && accept && in_opcode == OPC_LOAD) begin
      sx_r <= in_start_x;
      sy_r <= in_start_y;
      ex_r <= in_end_x;
      ey_r <= in_end_y;
    end
    if (state_r == ST_DELTA) begin
      dx_r <= POS_W'(ex_r) - POS_W'(sx_r);
      dy_r <= POS_W'(ey_r) - POS_W'(sy_r);
    end
    if (state_r == ST_SETUP) begin
      x_major_r <= su_xm;
      single_r  <= su_single;
      neg_r     <= su_neg;
      pos_r     <= POS_W'(su_ms);
      end_r     <= POS_W'(su_me);
      acc_r     <= ACC_W'(su_ns) <<< FRAC_BITS;
      slope_r   <= '0;
    end
    if (state_r == ST_DIV && div_done) begin
      slope_r <= neg_r ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    end
    if (state_r == ST_STEP && !st_over) begin
      pos_r      <= pos_r + POS_W'(1);
      acc_r      <= acc_r + ACC_W'(slope_r);
      req_r.x    <= x_major_r ? pos_ext : minor;
      req_r.y    <= x_major_r ? minor : pos_ext;
      req_r.last <= st_last;
    end
  end

  dlr_div #(
    .NUM_W (NUM_W),
    .DEN_W (MAG_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (su_num),
    .den      (dmaj[MAG_W-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  dlr_pixel u_pixel (
    .clk               (clk),
    .rst_n             (rst_n),
    .window_width      (width_r),
    .window_height     (height_r),
    .draw_color        (color_r),
    .start             (pix_start),
    .req               (req_r),
    .ready             (pix_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_write_valid   (out_write_valid),
    .out_last_pixel    (out_last_pixel)
  );

endmodule

`default_nettype wire

/* tb/tb_dda_line_rasterizer_unit.sv */
`timescale 1ns / 1ps

module tb_dda_line_rasterizer_unit;
  import dlr_pkg::*;

  localparam int MAX_DIM = 4096;
  localparam int FRAC_BITS = 16;
  localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 64;
  localparam int N_PLOT_ROWS = 25;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 120;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               wv;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic                         op;
    logic signed [COORD_IN_W-1:0] sx;
    logic signed [COORD_IN_W-1:0] sy;
    logic signed [COORD_IN_W-1:0] ex;
    logic signed [COORD_IN_W-1:0] ey;
    logic                         known;
    logic [ADDR_W-1:0]            addr;
    logic                         wv;
    logic                         last;
  } plot_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic signed [COORD_IN_W-1:0] in_start_x = '0;
  logic signed [COORD_IN_W-1:0] in_start_y = '0;
  logic signed [COORD_IN_W-1:0] in_end_x = '0;
  logic signed [COORD_IN_W-1:0] in_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ADDR_W-1:0] out_pixel_address;
  logic [COLOR_W-1:0] out_pixel_color;
  logic out_write_valid;
  logic out_last_pixel;

  // Typed-in expectation that travels with the item on the input channel.
  logic in_known = 1'b0;
  pixel_t in_known_px = '0;

  dda_line_rasterizer_unit #(
    .MAX_DIM(MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_start_x(in_start_x),
    .in_start_y(in_start_y),
    .in_end_x(in_end_x),
    .in_end_y(in_end_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pixel_address(out_pixel_address),
    .out_pixel_color(out_pixel_color),
    .out_write_valid(out_write_valid),
    .out_last_pixel(out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  int win_w = int'(WIDTH_RESET);
  int win_h = int'(HEIGHT_RESET);
  logic [COLOR_W-1:0] draw_rgb = COLOR_RESET;
  int maj_pos = 0;
  int maj_end = 0;
  longint minor_acc = 0;
  longint slope = 0;
  bit x_major = 1'b0;
  bit active = 1'b0;
  bit single_pt = 1'b0;

  pixel_t pixel_q[$];
  int bad_pixels = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit stall_now = 1'b0;
  int hold_left = 0;

  function automatic int saturate_dim(logic [CFG_DATA_W-1:0] v);
    int d;
    d = int'(v[DIM_W-1:0]);
    return (d > MAX_DIM) ? MAX_DIM : d;
  endfunction

  task automatic raster_load(int sx, int sy, int ex, int ey);
    int dx, dy, adx, ady, ms, me, ns, ne, t;
    dx = ex - sx;
    dy = ey - sy;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    active = 1'b1;
    single_pt = 1'b0;
    if (dx != 0 && adx >= ady) begin
      x_major = 1'b1;
      ms = sx; me = ex; ns = sy; ne = ey;
    end else if (dy != 0) begin
      x_major = 1'b0;
      ms = sy; me = ey; ns = sx; ne = ex;
    end else begin
      x_major = 1'b1;
      single_pt = 1'b1;
      ms = sx; me = sx; ns = sy; ne = sy;
    end
    if (ms > me) begin
      t = ms; ms = me; me = t;
      t = ns; ns = ne; ne = t;
    end
    maj_pos = ms;
    maj_end = me;
    minor_acc = longint'(ns) * FRAC_ONE;
    slope = single_pt ? 0 : (longint'(ne - ns) * FRAC_ONE) / longint'(me - ms);
  endtask

  task automatic raster_step(output bit emitted, output pixel_t px);
    int lim, dim;
    longint minor, px_x, px_y, lin;
    bit in_win, fin;
    emitted = 1'b0;
    px = '0;
    if (!active) return;
    lim = maj_end;
    if (!single_pt) begin
      dim = x_major ? win_w : win_h;
      if (dim < lim) lim = dim;
    end
    if (maj_pos > lim) begin
      active = 1'b0;
      return;
    end
    minor = minor_acc / FRAC_ONE;
    px_x = x_major ? longint'(maj_pos) : minor;
    px_y = x_major ? minor : longint'(maj_pos);
    in_win = px_x >= 0 && px_x < win_w && px_y >= 0 && px_y < win_h;
    fin = maj_pos >= lim;
    lin = px_y * win_w + px_x;
    px.addr = in_win ? lin[ADDR_W-1:0] : '0;
    px.color = draw_rgb;
    px.wv = in_win;
    px.last = fin;
    emitted = 1'b1;
    maj_pos = maj_pos + 1;
    minor_acc = minor_acc + slope;
    if (fin) active = 1'b0;
  endtask

  task automatic report_bad(string what, pixel_t want, pixel_t got);
    bad_pixels++;
    if (bad_pixels <= 10) begin
      $display("%0t %s: expected addr=%h color=%h wv=%b last=%b", $realtime, what,
               want.addr, want.color, want.wv, want.last);
      $display("    got addr=%h color=%h wv=%b last=%b",
               got.addr, got.color, got.wv, got.last);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    pixel_t want, got, px;
    bit emitted, moved;
    moved = 1'b0;
    if (out_valid && !out_stall) begin
      moved = 1'b1;
      got = '{out_pixel_address, out_pixel_color, out_write_valid, out_last_pixel};
      if (pixel_q.size() == 0) begin
        report_bad("unexpected pixel", '0, got);
      end else begin
        want = pixel_q.pop_front();
        if (got !== want) report_bad("pixel mismatch", want, got);
      end
    end
    if (in_valid && !in_stall) begin
      moved = 1'b1;
      if (in_opcode == OPC_LOAD) begin
        raster_load(int'(in_start_x), int'(in_start_y), int'(in_end_x), int'(in_end_y));
      end else begin
        raster_step(emitted, px);
        if (emitted) pixel_q.push_back(in_known ? in_known_px : px);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  always @(posedge clk) begin : out_stall_gen
    int unsigned r;
    if (hold_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        stall_now = 1'b0;
        hold_left = $urandom_range(1, 6);
      end else if (r < 95) begin
        stall_now = 1'b1;
        hold_left = $urandom_range(1, 3);
      end else begin
        stall_now = 1'b1;
        hold_left = $urandom_range(10, 40);
      end
    end
    hold_left = hold_left - 1;
    out_stall <= stall_now && !calm;
  end

  function automatic int pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(logic op, logic signed [COORD_IN_W-1:0] sx,
                           logic signed [COORD_IN_W-1:0] sy,
                           logic signed [COORD_IN_W-1:0] ex,
                           logic signed [COORD_IN_W-1:0] ey,
                           logic known, pixel_t kpx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x <= ex;
    in_end_y <= ey;
    in_known <= known;
    in_known_px <= kpx;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_plain(logic op, int sx, int sy, int ex, int ey);
    send_item(op, sx[COORD_IN_W-1:0], sy[COORD_IN_W-1:0], ex[COORD_IN_W-1:0],
              ey[COORD_IN_W-1:0], 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_IDX_WIDTH: win_w = saturate_dim(data);
      CFG_IDX_HEIGHT: win_h = saturate_dim(data);
      CFG_IDX_COLOR: draw_rgb = data;
      default: ;
    endcase
  endtask

  task automatic run_phase(int n_items);
    int sent, kind, len, dx, dy, sx, sy, n_steps, adx, ady;
    sent = 0;
    while (sent < n_items) begin
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        sx = int'($urandom_range(0, win_w + 16)) - 8;
        sy = int'($urandom_range(0, win_h + 16)) - 8;
        len = ($urandom_range(0, 9) == 0) ? 60 : 12;
        dx = int'($urandom_range(0, 2 * len)) - len;
        dy = int'($urandom_range(0, 2 * len)) - len;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        send_plain(OPC_LOAD, sx, sy, sx + dx, sy + dy);
        n_steps = ((adx > ady) ? adx : ady) + 1 + $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) n_steps = $urandom_range(0, n_steps);
        repeat (n_steps) send_plain(OPC_STEP, $urandom, $urandom, $urandom, $urandom);
        sent += n_steps + 1;
      end else if (kind < 85) begin
        send_plain(OPC_LOAD, $urandom, $urandom, $urandom, $urandom);
        n_steps = $urandom_range(0, 4);
        repeat (n_steps) send_plain(OPC_STEP, $urandom, $urandom, $urandom, $urandom);
        sent += n_steps + 1;
      end else if (kind < 95) begin
        if ($urandom_range(0, 1) == 0) begin
          sx = int'($urandom_range(0, win_w + 4)) - 2;
          sy = int'($urandom_range(0, win_h + 4)) - 2;
        end else begin
          sx = $urandom;
          sy = $urandom;
        end
        send_plain(OPC_LOAD, sx, sy, sx, sy);
        n_steps = $urandom_range(1, 2);
        repeat (n_steps) send_plain(OPC_STEP, $urandom, $urandom, $urandom, $urandom);
        sent += n_steps + 1;
      end else begin
        send_plain(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
        sent += 1;
      end
      if ($urandom_range(0, 49) == 0) drain();
    end
    calm = 1'b0;
  endtask

  plot_row_t plot_rows [0:N_PLOT_ROWS-1] = '{
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 24'd0, 1'b1, 1'b1},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_LOAD, 16'sd1023, 16'sd767, 16'sd1023, 16'sd767, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 24'd786431, 1'b1, 1'b1},
    '{OPC_LOAD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 24'd0, 1'b0, 1'b1},
    '{OPC_LOAD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_STEP, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b1, 24'd0, 1'b0, 1'b1},
    '{OPC_LOAD, 16'sd0, 16'sd5, 16'sd3, 16'sd5, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 24'd5120, 1'b1, 1'b0},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 24'd5121, 1'b1, 1'b0},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 24'd5122, 1'b1, 1'b0},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 24'd5123, 1'b1, 1'b1},
    '{OPC_LOAD, 16'sd3, 16'sd0, 16'sd0, 16'sd3, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_LOAD, 16'sd2, 16'sd10, 16'sd2, 16'sd7, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_LOAD, 16'sd2000, 16'sd0, 16'sd3000, 16'sd10, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_LOAD, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{OPC_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 24'd0, 1'b0, 1'b0}
  };

  initial begin : stimulus
    plot_row_t row;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_PLOT_ROWS; i++) begin
      row = plot_rows[i];
      send_item(row.op, row.sx, row.sy, row.ex, row.ey, row.known,
                '{row.addr, COLOR_RESET, row.wv, row.last});
    end
    drain();
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_IDX_WIDTH, 32'd16);
          write_reg(CFG_IDX_HEIGHT, 32'd12);
          write_reg(CFG_IDX_COLOR, $urandom);
        end
        1: begin
          write_reg(CFG_IDX_WIDTH, 32'd1);
          write_reg(CFG_IDX_HEIGHT, 32'd1);
          write_reg(CFG_IDX_COLOR, 32'h0000_0000);
        end
        2: begin
          write_reg(CFG_IDX_WIDTH, 32'd4096);
          write_reg(CFG_IDX_HEIGHT, 32'd4096);
          write_reg(CFG_IDX_COLOR, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(CFG_IDX_WIDTH, 32'h0000_2000);
          write_reg(CFG_IDX_HEIGHT, 32'd37);
          write_reg(CFG_IDX_COLOR, $urandom);
        end
        4: begin
          write_reg(CFG_IDX_WIDTH, 32'hFFFF_FFFF);
          write_reg(CFG_IDX_HEIGHT, 32'd0);
          write_reg(CFG_IDX_SPARE, $urandom);
        end
        5: begin
          write_reg(CFG_IDX_WIDTH, $urandom_range(1, 200));
          write_reg(CFG_IDX_HEIGHT, $urandom_range(1, 200));
          write_reg(CFG_IDX_COLOR, $urandom);
        end
        6: begin
          write_reg(CFG_IDX_WIDTH, 32'd640);
          write_reg(CFG_IDX_HEIGHT, 32'd480);
        end
        default: begin
          write_reg(CFG_IDX_WIDTH, {19'($urandom), 13'($urandom_range(4097, 8191))});
          write_reg(CFG_IDX_HEIGHT, $urandom_range(1, 64));
          write_reg(CFG_IDX_COLOR, $urandom);
        end
      endcase
      run_phase(ITEMS_PER_PHASE);
      drain();
    end
    if (bad_pixels == 0 && pixel_q.size() == 0) begin
      $display("** dda_line_rasterizer_unit: PASSED **");
    end else begin
      $display("** dda_line_rasterizer_unit: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("** dda_line_rasterizer_unit: FAILED **");
    $finish;
  end

endmodule

/* files.f */
hdl/dlr_pkg.sv
hdl/dlr_div.sv
hdl/dlr_pixel.sv
hdl/dda_line_rasterizer_unit.sv
tb/tb_dda_line_rasterizer_unit.sv
